// File: rtl/core/assert_macros.svh
// Assertion macros shared by the frame parser RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/lpfp_pkg.sv
// Types and constants for the length-prefixed frame parser.
// No dependencies; imported by the output buffer and the top level.
`default_nettype none

package lpfp_pkg;

  localparam int unsigned LENGTH_BYTES = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [DATA_W-1:0] MAX_FRAME_LEN_RESET = 32'd65536;
  localparam logic [0:0] REG_MAX_FRAME_LEN = 1'b0;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       bad_length;
  } frame_word_t;

endpackage

`default_nettype wire

// File: rtl/core/lpfp_stream_if.sv
// Valid/ready channel interfaces for the frame parser: raw byte input
// and frame word output. No dependencies.
`default_nettype none

interface lpfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_of_frame;
  logic       bad_length;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output bad_length, input ready);
  modport sink (input valid, input payload_byte, input last_of_frame,
                input bad_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lpfp_out_buf.sv
// Two-entry output buffer driving the frame word channel.
// Depends on lpfp_pkg, lpfp_stream_if.sv and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lpfp_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire lpfp_pkg::frame_word_t push_word,
  output logic                     full,
  lpfp_frame_if.source             frame_out
);
  import lpfp_pkg::*;

  frame_word_t head;
  frame_word_t spare;
  logic        head_valid;
  logic        spare_valid;
  logic        pop;

  assign pop  = head_valid & frame_out.ready;
  assign full = head_valid & spare_valid;

  assign frame_out.valid         = head_valid;
  assign frame_out.payload_byte  = head.payload_byte;
  assign frame_out.last_of_frame = head.last_of_frame;
  assign frame_out.bad_length    = head.bad_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!head_valid) begin
      if (push) begin
        head       <= push_word;
        head_valid <= 1'b1;
      end
    end else if (!spare_valid) begin
      if (pop && push) begin
        head <= push_word;
      end else if (pop) begin
        head_valid <= 1'b0;
      end else if (push) begin
        spare       <= push_word;
        spare_valid <= 1'b1;
      end
    end else if (pop) begin
      head        <= spare;
      spare_valid <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_no_push_when_full, clk, full |-> !push, "word pushed into full buffer")
  `ASSERT_RST(a_spare_needs_head, clk, rst, spare_valid |-> head_valid,
              "spare entry held without head")
  `ASSERT_RST(a_spare_kept, clk, rst, (spare_valid && !pop) |=> (spare_valid && $stable(spare)),
              "spare word lost while head stalled")

endmodule

`default_nettype wire

// File: rtl/core/length_prefixed_frame_parser.sv
// Length-prefixed frame parser top level: header decode, frame state,
// configuration port. Depends on lpfp_pkg, lpfp_stream_if.sv, lpfp_out_buf.

// One byte is accepted every clock cycle while ready is high. Each frame
// starts with a 4-byte big-endian payload length; the payload bytes then
// come out one per word, registered, the final one marked last_of_frame.
// A length of zero or above max_frame_len (APB register at address 0,
// reset 65536) gives a single word with bad_length set, after which all
// input is taken and dropped until reset. A two-word output buffer lets
// input continue while one word waits; ready falls only while both buffer
// entries are held.
`default_nettype none

`include "assert_macros.svh"

module length_prefixed_frame_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  lpfp_byte_if.sink                         byte_in,
  lpfp_frame_if.source                      frame_out,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lpfp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lpfp_pkg::DATA_W-1:0]  pwdata,
  output logic [lpfp_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import lpfp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROPPED = 2'd2
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [1:0]        header_bytes_seen;
  logic [1:0]        header_bytes_seen_next;
  logic [31:0]       length_shift;
  logic [31:0]       length_shift_next;
  logic [31:0]       bytes_remaining;
  logic [31:0]       bytes_remaining_next;
  logic [DATA_W-1:0] max_frame_len;

  logic        accept;
  logic        full;
  logic        push;
  frame_word_t push_word;
  logic [31:0] hdr_len;
  logic        last_hdr;
  logic        reg_sel;

  assign byte_in.ready = !full;
  assign accept        = byte_in.valid & byte_in.ready;
  assign hdr_len       = {length_shift[23:0], byte_in.in_byte};
  assign last_hdr      = header_bytes_seen == 2'(LENGTH_BYTES - 1);

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_MAX_FRAME_LEN) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_sel ? max_frame_len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_FRAME_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_frame_len <= pwdata;
    end
  end

  always_comb begin
    phase_next             = phase;
    header_bytes_seen_next = header_bytes_seen;
    length_shift_next      = length_shift;
    bytes_remaining_next   = bytes_remaining;
    push                   = 1'b0;
    push_word              = '0;
    unique case (phase)
      PH_HEADER: begin
        if (!last_hdr) begin
          length_shift_next      = hdr_len;
          header_bytes_seen_next = header_bytes_seen + 2'd1;
        end else begin
          header_bytes_seen_next = 2'd0;
          length_shift_next      = '0;
          if (hdr_len == 32'd0 || hdr_len > max_frame_len) begin
            phase_next           = PH_DROPPED;
            push                 = accept;
            push_word.bad_length = 1'b1;
          end else begin
            phase_next           = PH_PAYLOAD;
            bytes_remaining_next = hdr_len;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_remaining_next    = bytes_remaining - 32'd1;
        push                    = accept;
        push_word.payload_byte  = byte_in.in_byte;
        push_word.last_of_frame = bytes_remaining == 32'd1;
        if (bytes_remaining == 32'd1) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_bytes_seen <= 2'd0;
      length_shift      <= '0;
      bytes_remaining   <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      header_bytes_seen <= header_bytes_seen_next;
      length_shift      <= length_shift_next;
      bytes_remaining   <= bytes_remaining_next;
    end
  end

  lpfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .frame_out (frame_out)
  );

  `ASSERT_RST(a_bad_then_drop, clk, rst, (push && push_word.bad_length) |=> (phase == PH_DROPPED),
              "error word without dropped phase")
  `ASSERT_RST(a_drop_sticks, clk, rst, (phase == PH_DROPPED) |=> (phase == PH_DROPPED),
              "dropped phase left before reset")
  `ASSERT_RST(a_payload_count, clk, rst, (phase == PH_PAYLOAD) |-> (bytes_remaining != 32'd0),
              "payload phase with nothing remaining")

endmodule

`default_nettype wire
